>>> sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: label failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: label failed");

`endif

>>> sv/yld_pkg.sv
`timescale 1ns / 1ps

package yld_pkg;

   typedef enum logic [1:0] {
      KIND_DATA       = 2'd0,
      KIND_END        = 2'd1,
      KIND_BAD_BYTE   = 2'd2,
      KIND_BAD_ESCAPE = 2'd3
   } kind_type;

   localparam logic [7:0] ESC_CHAR   = 8'd61;
   localparam logic [7:0] ESC_SHIFT  = 8'd64;
   localparam logic [7:0] DATA_SHIFT = 8'd42;
   localparam logic [7:0] LF_CHAR    = 8'd10;
   localparam logic [7:0] CR_CHAR    = 8'd13;
   localparam logic [7:0] NUL_CHAR   = 8'd0;

   // Result of decoding one byte together with the decoder state it leaves.
   typedef struct packed {
      logic       emit;
      kind_type   kind;
      logic [7:0] byte_out;
      logic       escape_next;
      logic       error_next;
   } dec_result_type;

endpackage

>>> sv/yld_decode.sv
`timescale 1ns / 1ps

module yld_decode (
   input  logic                    escape_pending,
   input  logic                    error_latched,
   input  logic [7:0]              raw_byte,
   output yld_pkg::dec_result_type result
);
   import yld_pkg::*;

   logic [7:0] unescaped;

   assign unescaped = raw_byte - ESC_SHIFT;

   always_comb begin
      result.emit        = 1'b0;
      result.kind        = KIND_DATA;
      result.byte_out    = 8'd0;
      result.escape_next = escape_pending;
      result.error_next  = error_latched;

      if (error_latched) begin
         // Everything after an error is dropped and the escape flag is kept.
         result.emit = 1'b0;
      end else if (escape_pending) begin
         result.escape_next = 1'b0;
         result.emit        = 1'b1;
         if (unescaped == NUL_CHAR || unescaped == LF_CHAR ||
             unescaped == CR_CHAR  || unescaped == ESC_CHAR) begin
            result.byte_out = unescaped - DATA_SHIFT;
         end else begin
            result.kind       = KIND_BAD_ESCAPE;
            result.error_next = 1'b1;
         end
      end else if (raw_byte == LF_CHAR) begin
         result.emit = 1'b1;
         result.kind = KIND_END;
      end else if (raw_byte == NUL_CHAR || raw_byte == CR_CHAR) begin
         result.emit       = 1'b1;
         result.kind       = KIND_BAD_BYTE;
         result.error_next = 1'b1;
      end else if (raw_byte == ESC_CHAR) begin
         result.escape_next = 1'b1;
      end else begin
         result.emit     = 1'b1;
         result.byte_out = raw_byte - DATA_SHIFT;
      end
   end

endmodule

>>> sv/yld_out_reg.sv
`timescale 1ns / 1ps

module yld_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  yld_pkg::kind_type   kind,
   input  logic [7:0]          byte_out,
   output logic                can_load,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic [1:0]          rsp_tuser
);
   import yld_pkg::*;

   logic       valid_ff;
   kind_type   kind_ff;
   logic [7:0] byte_ff;

   // A new result may enter when the register is empty or its transfer completes now.
   assign can_load = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_load) begin
         valid_ff <= load;
      end
      if (can_load && load) begin
         kind_ff <= kind;
         byte_ff <= byte_out;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = kind_ff;

endmodule

>>> sv/yenc_line_decoder_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tdata[7:0] raw_byte
// rsp       out  rsp_tvalid/rsp_tready  tdata[7:0] byte_out, tuser[1:0] kind
//
// One byte is accepted per cycle unless a stalled rsp side holds it off; a result
// passes through the input register, then the result register. The decode between
// the two registers is three subtracts and a few compares. Reset clears both valid
// flags, the escape flag and the error flag. A stalled rsp side backs up into
// req_tready only when both registers are full and the held byte would produce a result.

module yenc_line_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] raw_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] byte_out
   output logic [1:0] rsp_tuser    // [1:0] kind
);
   import yld_pkg::*;

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           escape_ff;
   logic           error_ff;
   dec_result_type dec;
   logic           out_can_load;
   logic           advance;

   yld_decode u_decode (
      .escape_pending (escape_ff),
      .error_latched  (error_ff),
      .raw_byte       (in_byte_ff),
      .result         (dec)
   );

   // The held byte leaves when it yields nothing or the result register can take it.
   assign advance    = in_valid_ff && (!dec.emit || out_can_load);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         escape_ff   <= 1'b0;
         error_ff    <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            escape_ff <= dec.escape_next;
            error_ff  <= dec.error_next;
         end
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   yld_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && dec.emit),
      .kind       (dec.kind),
      .byte_out   (dec.byte_out),
      .can_load   (out_can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> sv/yld_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module yld_assertions (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser
);
   import yld_pkg::*;

   logic rsp_xfer;
   logic err_xfer;

   assign rsp_xfer = rsp_tvalid && rsp_tready;
   assign err_xfer = rsp_xfer &&
                     (rsp_tuser == KIND_BAD_BYTE || rsp_tuser == KIND_BAD_ESCAPE);

   // A stalled result keeps its contents.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Only data results carry a byte.
   `ASSERT_SAME(a_nondata_zero, clock, reset, rsp_tvalid && rsp_tuser != KIND_DATA,
                rsp_tdata == 8'd0)

   // An error is the last result until reset.
   `ASSERT_NEXT(a_err_last, clock, reset, err_xfer, !rsp_tvalid)

   // The input side is never held off while the block is empty on the result side.
   `ASSERT_SAME(a_ready_free, clock, reset, !rsp_tvalid, req_tready)

endmodule

bind yenc_line_decoder_top yld_assertions u_yld_checker (.*);
